FILE: design/assert_macros.svh
// assertion macros shared by the rtl
// expects clk_i and rst_ni in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every rising clock edge outside reset
`define TFTI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression never true outside reset
`define TFTI_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

FILE: design/tfti_pkg.sv
// types and constants of the timed fix table interpolator
// no dependencies
package tfti_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned TimeW      = 64;
  localparam int unsigned LatW       = 31;
  localparam int unsigned LonW       = 32;
  // coordinate difference and quotient width
  localparam int unsigned CoordW     = 33;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NOP    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  typedef struct packed {
    logic [TimeW-1:0] tm;
    logic [LatW-1:0]  lat;
    logic [LonW-1:0]  lon;
  } entry_t;

endpackage

FILE: design/tfti_if.sv
// request and response channels of the timed fix table interpolator
// depends on tfti_pkg
interface tfti_req_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     req_type;
  logic signed [tfti_pkg::TimeW-1:0] fix_time;
  logic signed [tfti_pkg::LatW-1:0]  fix_lat;
  logic signed [tfti_pkg::LonW-1:0]  fix_lon;
  modport source (output valid, req_type, fix_time, fix_lat, fix_lon, input ready);
  modport sink   (input valid, req_type, fix_time, fix_lat, fix_lon, output ready);
endinterface

interface tfti_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic signed [tfti_pkg::LatW-1:0] pos_lat;
  logic signed [tfti_pkg::LonW-1:0] pos_lon;
  modport source (output valid, status, pos_lat, pos_lon, input ready);
  modport sink   (input valid, status, pos_lat, pos_lon, output ready);
endinterface

FILE: design/timed_fix_table_interpolator_unit.sv
// timed fix table interpolator: sorted fix memory, binary search, iterative lerp
// clear, nop, empty query and full insert go straight to the response; insert searches,
// shifts and writes; query searches, reads two fixes and lerps; one transaction at a time
// throughput set by the memory read port, the shared 65-bit add/sub and any held response
// reset clears the fill count and control state; the memory is not cleared
// depends on tfti_pkg, tfti_if and assert_macros.svh
`include "assert_macros.svh"

module timed_fix_table_interpolator_unit #(
  parameter int unsigned TABLE_DEPTH = tfti_pkg::TableDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tfti_req_if.sink    req_i,
  tfti_rsp_if.source  rsp_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned TW = tfti_pkg::TimeW;
  localparam int unsigned KW = tfti_pkg::CoordW;
  localparam int unsigned SW = $clog2(tfti_pkg::CoordW);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);
  localparam logic [SW-1:0] LastStep = SW'(tfti_pkg::CoordW - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_SHIFT_RD, S_SHIFT_WR, S_INS_WR,
    S_Q_RDB, S_Q_RDA, S_Q_SET, S_LERP_SET, S_MUL, S_DIV, S_LERP_END, S_RESP
  } state_e;

  // fix memory, one write and one registered read port
  tfti_pkg::entry_t mem_q [TABLE_DEPTH];
  tfti_pkg::entry_t rd_data_q;
  tfti_pkg::entry_t wr_data;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic             wr_en;

  state_e           state_q;
  logic [CW-1:0]    cnt_q, lo_q, hi_q, sp_q;
  logic [1:0]       req_q;
  logic [TW-1:0]    t_q;
  logic [tfti_pkg::LatW-1:0] lat_q;
  logic [tfti_pkg::LonW-1:0] lon_q;
  tfti_pkg::entry_t a_q, b_q;
  logic [TW-1:0]    off_q, gap_q;
  logic             coord_q, neg_q;
  logic [KW-1:0]    base_q;
  logic [TW:0]      p_hi_q;       // upper product bits, remainder during divide
  logic [KW-1:0]    p_lo_q;       // multiplier bits, then quotient bits
  logic [SW-1:0]    step_q;
  logic [1:0]       res_st_q;
  logic [tfti_pkg::LatW-1:0] res_lat_q;
  logic [tfti_pkg::LonW-1:0] res_lon_q;
  logic             out_vld_q;
  logic [1:0]       out_st_q;
  logic [tfti_pkg::LatW-1:0] out_lat_q;
  logic [tfti_pkg::LonW-1:0] out_lon_q;

  logic [CW-1:0]    mid, cnt_m1;
  logic             t_lt_mid, mid_lt_t;

  // shared add/sub unit for shift-add multiply and restoring divide
  logic [TW:0]      alu_a, alu_b;
  logic             alu_sub;
  logic [TW+1:0]    alu_res;
  logic [TW:0]      div_rem;
  logic             div_ge;
  logic [TW:0]      mul_sum;

  // coordinate set-up for the current lerp
  logic [KW-1:0]    ca, cb, cdiff, cmag, cres;

  assign mid    = lo_q + ((hi_q - lo_q) >> 1);
  assign cnt_m1 = cnt_q - CW'(1);
  assign t_lt_mid = $signed(t_q) < $signed(rd_data_q.tm);
  assign mid_lt_t = $signed(rd_data_q.tm) < $signed(t_q);

  assign div_rem = {p_hi_q[TW-1:0], p_lo_q[KW-1]};
  assign alu_a   = (state_q == S_DIV) ? div_rem : p_hi_q;
  assign alu_b   = (state_q == S_DIV) ? {1'b0, gap_q} : {1'b0, off_q};
  assign alu_sub = (state_q == S_DIV);
  assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});
  assign div_ge  = !alu_res[TW+1];
  assign mul_sum = p_lo_q[0] ? alu_res[TW:0] : p_hi_q;

  always_comb begin
    if (coord_q) begin
      ca = {a_q.lon[tfti_pkg::LonW-1], a_q.lon};
      cb = {b_q.lon[tfti_pkg::LonW-1], b_q.lon};
    end else begin
      ca = {{2{a_q.lat[tfti_pkg::LatW-1]}}, a_q.lat};
      cb = {{2{b_q.lat[tfti_pkg::LatW-1]}}, b_q.lat};
    end
    cdiff = cb - ca;
    cmag  = cdiff[KW-1] ? (~cdiff + KW'(1)) : cdiff;
    cres  = neg_q ? (base_q - p_lo_q) : (base_q + p_lo_q);
  end

  // memory address and write control
  always_comb begin
    rd_addr = mid[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = sp_q[AW-1:0];
    wr_data = rd_data_q;
    case (state_q)
      S_SHIFT_RD: rd_addr = cnt_m1[AW-1:0] - AW'(cnt_q - sp_q);
      S_SHIFT_WR: wr_en = 1'b1;
      S_INS_WR: begin
        wr_en   = 1'b1;
        wr_addr = lo_q[AW-1:0];
        wr_data = '{tm: t_q, lat: lat_q, lon: lon_q};
      end
      S_Q_RDB: rd_addr = (lo_q == cnt_q) ? cnt_m1[AW-1:0] : lo_q[AW-1:0];
      S_Q_RDA: rd_addr = lo_q[AW-1:0] - AW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
      coord_q   <= 1'b0;
    end else begin
      // in S_RESP the output register is refilled below instead
      if (out_vld_q && rsp_o.ready && (state_q != S_RESP)) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            req_q     <= req_i.req_type;
            t_q       <= req_i.fix_time;
            lat_q     <= req_i.fix_lat;
            lon_q     <= req_i.fix_lon;
            lo_q      <= '0;
            hi_q      <= cnt_q;
            res_st_q  <= tfti_pkg::ST_OK;
            res_lat_q <= '0;
            res_lon_q <= '0;
            coord_q   <= 1'b0;
            case (req_i.req_type)
              tfti_pkg::REQ_CLEAR: begin
                cnt_q   <= '0;
                state_q <= S_RESP;
              end
              tfti_pkg::REQ_INSERT: begin
                if (cnt_q >= DepthC) begin
                  res_st_q <= tfti_pkg::ST_FULL;
                  state_q  <= S_RESP;
                end else begin
                  state_q <= S_SRCH_RD;
                end
              end
              tfti_pkg::REQ_QUERY: begin
                if (cnt_q == '0) begin
                  res_st_q <= tfti_pkg::ST_EMPTY;
                  state_q  <= S_RESP;
                end else begin
                  state_q <= S_SRCH_RD;
                end
              end
              default: state_q <= S_RESP;
            endcase
          end
        end
        S_SRCH_RD: begin
          if (lo_q == hi_q) begin
            sp_q    <= cnt_q;
            state_q <= (req_q == tfti_pkg::REQ_INSERT) ? S_SHIFT_RD : S_Q_RDB;
          end else begin
            state_q <= S_SRCH_CMP;
          end
        end
        S_SRCH_CMP: begin
          // insert: first entry later than t; query: first entry not before t
          if (req_q == tfti_pkg::REQ_INSERT) begin
            if (t_lt_mid) hi_q <= mid;
            else          lo_q <= mid + CW'(1);
          end else begin
            if (mid_lt_t) lo_q <= mid + CW'(1);
            else          hi_q <= mid;
          end
          state_q <= S_SRCH_RD;
        end
        S_SHIFT_RD: begin
          state_q <= (sp_q == lo_q) ? S_INS_WR : S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          sp_q    <= sp_q - CW'(1);
          state_q <= S_SHIFT_RD;
        end
        S_INS_WR: begin
          cnt_q   <= cnt_q + CW'(1);
          state_q <= S_RESP;
        end
        S_Q_RDB: state_q <= S_Q_RDA;
        S_Q_RDA: begin
          b_q <= rd_data_q;
          if (lo_q == '0 || lo_q == cnt_q) begin
            // at or before the first or past the last fix
            res_lat_q <= rd_data_q.lat;
            res_lon_q <= rd_data_q.lon;
            state_q   <= S_RESP;
          end else begin
            state_q <= S_Q_SET;
          end
        end
        S_Q_SET: begin
          a_q     <= rd_data_q;
          off_q   <= t_q - rd_data_q.tm;
          gap_q   <= b_q.tm - rd_data_q.tm;
          state_q <= S_LERP_SET;
        end
        S_LERP_SET: begin
          base_q  <= ca;
          neg_q   <= cdiff[KW-1];
          p_hi_q  <= '0;
          p_lo_q  <= cmag;
          step_q  <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          p_hi_q <= {1'b0, mul_sum[TW:1]};
          p_lo_q <= {mul_sum[0], p_lo_q[KW-1:1]};
          step_q <= step_q + SW'(1);
          if (step_q == LastStep) begin
            step_q  <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          // quotient fits in the coordinate width, so only its low bits are formed
          p_hi_q <= div_ge ? alu_res[TW:0] : div_rem;
          p_lo_q <= {p_lo_q[KW-2:0], div_ge};
          step_q <= step_q + SW'(1);
          if (step_q == LastStep) begin
            state_q <= S_LERP_END;
          end
        end
        S_LERP_END: begin
          if (coord_q) begin
            res_lon_q <= cres[tfti_pkg::LonW-1:0];
            state_q   <= S_RESP;
          end else begin
            res_lat_q <= cres[tfti_pkg::LatW-1:0];
            coord_q   <= 1'b1;
            state_q   <= S_LERP_SET;
          end
        end
        S_RESP: begin
          if (!out_vld_q || rsp_o.ready) begin
            out_vld_q <= 1'b1;
            out_st_q  <= res_st_q;
            out_lat_q <= res_lat_q;
            out_lon_q <= res_lon_q;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign req_i.ready   = (state_q == S_IDLE);
  assign rsp_o.valid   = out_vld_q;
  assign rsp_o.status  = out_st_q;
  assign rsp_o.pos_lat = out_lat_q;
  assign rsp_o.pos_lon = out_lon_q;

  `TFTI_ASSERT(a_cnt_bound, cnt_q <= DepthC, "fill count beyond table depth")
  `TFTI_NEVER(a_search_order, (state_q == S_SRCH_CMP) && (lo_q >= hi_q), "search bounds crossed")
  `TFTI_NEVER(a_full_status, (state_q == S_RESP) && (res_st_q == tfti_pkg::ST_FULL) && (cnt_q != DepthC), "full status with free entries")
  `TFTI_NEVER(a_div_rem, (state_q == S_DIV) && (p_hi_q >= {1'b0, gap_q}), "divide remainder not below gap")

endmodule

FILE: sim/testbench.sv
// self-checking testbench of the timed fix table interpolator
// depends on tfti_pkg, tfti_if and timed_fix_table_interpolator_unit
`timescale 1ns / 100ps

module testbench;
  import tfti_pkg::*;

  typedef struct {
    logic [1:0]         status;
    logic [LatW-1:0]    lat;
    logic [LonW-1:0]    lon;
  } position_t;

  // predictor of the fix table plus the list of responses still owed
  class fix_scoreboard;
    longint          times[$];
    logic [LatW-1:0] lats[$];
    logic [LonW-1:0] lons[$];
    position_t       owed[$];
    int              mismatches;
    int              checked;
    int              queries_lerped;
    int              fulls;

    function longint lerp(longint a, longint b, logic [63:0] off, logic [63:0] gap);
      longint       diff;
      logic [63:0]  mag;
      logic [127:0] prod;
      logic [63:0]  q;
      diff = b - a;
      mag  = (diff < 0) ? -diff : diff;
      prod = {64'd0, off} * {64'd0, mag};
      q    = 64'(prod / {64'd0, gap});
      return (diff < 0) ? a - longint'(q) : a + longint'(q);
    endfunction

    function void note_request(logic [1:0] req, longint t, logic [LatW-1:0] lat,
                               logic [LonW-1:0] lon);
      position_t p;
      int        idx;
      longint    la, lb, oa, ob;
      p.status = ST_OK;
      p.lat = '0;
      p.lon = '0;
      case (req)
        REQ_CLEAR: begin
          times.delete(); lats.delete(); lons.delete();
        end
        REQ_INSERT: begin
          if (times.size() >= TableDepth) begin
            p.status = ST_FULL;
            fulls++;
          end else begin
            // after every entry with equal or earlier time
            idx = 0;
            while (idx < times.size() && times[idx] <= t) idx++;
            times.insert(idx, t);
            lats.insert(idx, lat);
            lons.insert(idx, lon);
          end
        end
        REQ_QUERY: begin
          if (times.size() == 0) begin
            p.status = ST_EMPTY;
          end else begin
            idx = 0;
            while (idx < times.size() && times[idx] < t) idx++;
            if (idx >= times.size()) begin
              p.lat = lats[$];
              p.lon = lons[$];
            end else if (idx == 0) begin
              p.lat = lats[0];
              p.lon = lons[0];
            end else begin
              la = longint'($signed(lats[idx-1]));
              lb = longint'($signed(lats[idx]));
              oa = longint'($signed(lons[idx-1]));
              ob = longint'($signed(lons[idx]));
              p.lat = LatW'(lerp(la, lb, t - times[idx-1], times[idx] - times[idx-1]));
              p.lon = LonW'(lerp(oa, ob, t - times[idx-1], times[idx] - times[idx-1]));
              queries_lerped++;
            end
          end
        end
        default: ;
      endcase
      owed.insert(owed.size(), p);
    endfunction

    function void check_response(logic [1:0] status, logic [LatW-1:0] lat,
                                 logic [LonW-1:0] lon);
      position_t p;
      checked++;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response status %0d", status);
        return;
      end
      p = owed.pop_front();
      if (p.status !== status || p.lat !== lat || p.lon !== lon) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected st %0d lat %0d lon %0d, got st %0d lat %0d lon %0d",
                   p.status, $signed(p.lat), $signed(p.lon),
                   status, $signed(lat), $signed(lon));
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tfti_req_if req_bus();
  tfti_rsp_if rsp_bus();

  timed_fix_table_interpolator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  fix_scoreboard sb = new();
  bit calm;          // no idling in the closing stretch
  int sent;

  initial begin
    req_bus.valid    = 1'b0;
    req_bus.req_type = REQ_NOP;
    req_bus.fix_time = '0;
    req_bus.fix_lat  = '0;
    req_bus.fix_lon  = '0;
    rsp_bus.ready    = 1'b0;
  end

  // one request transaction; valid stays high for a back-to-back follower
  task automatic send_request(logic [1:0] req, longint t, logic [LatW-1:0] lat,
                              logic [LonW-1:0] lon);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk_i);
      req_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= req;
    req_bus.fix_time <= t;
    req_bus.fix_lat  <= lat;
    req_bus.fix_lon  <= lon;
    do @(posedge clk_i); while (!req_bus.ready);
    sb.note_request(req, t, lat, lon);
    sent++;
  endtask

  // hold the request side until every response has come back
  task automatic drain_responses();
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
  endtask

  function automatic longint pick_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return longint'($urandom_range(0, 6000)) - 3000;
    if (r < 95) return {$urandom, $urandom};
    return (r & 1) ? 64'h7fff_ffff_ffff_ffff : 64'h8000_0000_0000_0000;
  endfunction

  function automatic logic [LatW-1:0] pick_lat();
    if ($urandom_range(0, 4) == 0) return LatW'($urandom);
    return LatW'(longint'($urandom_range(0, 1800000000)) - 900000000);
  endfunction

  function automatic logic [LonW-1:0] pick_lon();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return LonW'(longint'($urandom_range(0, 2000000000)) * 9 / 5 - 1800000000);
  endfunction

  // response side: random stall bursts, check at the rising edge
  initial begin : response_sink
    int stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        rsp_bus.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        rsp_bus.ready <= 1'b0;
        stall_left = $urandom_range(1, 11) - 1;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
      @(posedge clk_i);
      if (rsp_bus.valid && rsp_bus.ready)
        sb.check_response(rsp_bus.status, rsp_bus.pos_lat, rsp_bus.pos_lon);
    end
  end

  initial begin : watchdog
    #20ms;
    $display("timeout with %0d responses outstanding", sb.owed.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int r;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty query, unused code, extremes, equal times, edges
    send_request(REQ_QUERY, 0, '0, '0);
    send_request(REQ_NOP, -1, '1, '1);
    send_request(REQ_INSERT, 64'h8000_0000_0000_0000, LatW'(-900000000), -1800000000);
    send_request(REQ_INSERT, 64'h7fff_ffff_ffff_ffff, LatW'(900000000), 1800000000);
    send_request(REQ_QUERY, 64'h8000_0000_0000_0000, '0, '0);
    send_request(REQ_QUERY, 64'h7fff_ffff_ffff_ffff, '0, '0);
    send_request(REQ_QUERY, 0, '1, '1);
    send_request(REQ_QUERY, -1, '0, '0);
    send_request(REQ_CLEAR, 0, '0, '0);
    send_request(REQ_QUERY, 5, '0, '0);
    send_request(REQ_INSERT, 100, LatW'(10), 20);
    send_request(REQ_INSERT, 100, LatW'(-30), -40);
    send_request(REQ_INSERT, 200, '1, '1);
    send_request(REQ_INSERT, 300, 31'h4000_0000, 32'h8000_0000);
    send_request(REQ_QUERY, 100, '0, '0);
    send_request(REQ_QUERY, 150, '0, '0);
    send_request(REQ_QUERY, 250, '0, '0);
    send_request(REQ_QUERY, 99, '0, '0);
    send_request(REQ_QUERY, 301, '0, '0);
    send_request(REQ_QUERY, 299, '0, '0);
    send_request(REQ_CLEAR, 0, '0, '0);
    drain_responses();

    // random mix, mostly inserts and queries on a compact time window
    for (int i = 0; i < 750; i++) begin
      if (i == 650) calm = 1'b1;
      if (i == 300) drain_responses();
      r = $urandom_range(0, 99);
      if (r < 3 || (r < 10 && sb.times.size() > 60))
        send_request(REQ_CLEAR, pick_time(), pick_lat(), pick_lon());
      else if (r < 6)
        send_request(REQ_NOP, pick_time(), pick_lat(), pick_lon());
      else if (r < 50)
        send_request(REQ_INSERT, pick_time(), pick_lat(), pick_lon());
      else
        send_request(REQ_QUERY, pick_time(), pick_lat(), pick_lon());
    end

    send_request(REQ_CLEAR, 0, '0, '0);
    send_request(REQ_QUERY, 0, '0, '0);

    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);

    $display("%0d requests sent, %0d responses checked", sent, sb.checked);
    $display("%0d interpolated queries, %0d full-table rejections, %0d mismatches",
             sb.queries_lerped, sb.fulls, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/tfti_pkg.sv
design/tfti_if.sv
design/timed_fix_table_interpolator_unit.sv
sim/testbench.sv
